### sv/mbrc_pkg.sv
package mbrc_pkg;

	typedef logic [15:0] crc_t;
	typedef logic [1:0]  status_t;

	localparam crc_t CRC_INIT = 16'hFFFF;
	localparam crc_t CRC_POLY = 16'hA001;
	localparam int   MIN_LEN  = 7;
	localparam logic [7:0] MIN_COUNT = 8'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_SHORT     = 2'd1;
	localparam status_t ST_CRC_ERR   = 2'd2;
	localparam status_t ST_COUNT_ERR = 2'd3;

endpackage

### sv/mbrc_crc_fold.sv
module mbrc_crc_fold import mbrc_pkg::*; (
	input  crc_t       crc_in,
	input  logic [7:0] data,
	output crc_t       crc_out
);

	always_comb begin
		crc_t c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

### sv/modbus_response_frame_checker.sv
// Modbus RTU response frame checker.
// Request channel rx: one frame byte per request (rx_byte), last_byte marks
// the final byte of a frame. Result channel res: one result per frame with
// frame_status (0 ok, 1 short, 2 CRC mismatch, 3 byte count below two),
// frame_ok and reg_value (bytes 3 and 4, zero when the frame is not ok).
// The CRC-16 runs over all bytes but the trailing checksum pair; one byte
// is held back so the checksum never enters the accumulator.
// Throughput: one byte per cycle, unless a last byte waits on a pending result.
// A byte is registered at acceptance, then held, and folded into the CRC by an
// unrolled eight-step XOR network when the next byte advances; a last byte
// writes its result into the result register when it leaves the input stage.
// Bytes beyond MAX_FRAME are dropped; a dropped last byte still ends the frame.
// Reset clears the frame state and the result valid flag; no result is shown.
// When the receiver stalls, the result register holds. Non-last bytes keep
// flowing; a last byte waits in the input stage, and rx_ready drops, until
// the pending result is taken.
module modbus_response_frame_checker import mbrc_pkg::*; #(
	parameter int MAX_FRAME = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	input  logic        last_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output status_t     frame_status,
	output logic        frame_ok,
	output logic [15:0] reg_value
);

	localparam int CntW = $clog2(MAX_FRAME + 1);
	localparam logic [CntW-1:0] MAX_C  = CntW'(MAX_FRAME);
	localparam logic [CntW-1:0] LAST_C = CntW'(MAX_FRAME - 1);

	logic            v_s1;
	logic [7:0]      byte_s1;
	logic            last_s1;
	logic            advance;

	crc_t            crc_q;
	logic [7:0]      held_q;
	logic [CntW-1:0] cnt_q;
	logic [7:0]      count_q;
	logic [7:0]      vhigh_q;
	logic [7:0]      vlow_q;

	logic            res_valid_q;
	status_t         status_q;
	logic [15:0]     value_q;

	crc_t            crc_folded;
	crc_t            chk;
	logic            in_buf;
	logic            at_end;
	logic            crc_match;
	logic [CntW-1:0] len_new;
	status_t         status_d;

	assign advance  = v_s1 && (!last_s1 || !res_valid_q || res_ready);
	assign rx_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx_ready) begin
			v_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
			last_s1 <= last_byte;
		end
	end

	mbrc_crc_fold u_fold (
		.crc_in  (crc_q),
		.data    (held_q),
		.crc_out (crc_folded)
	);

	always_comb begin
		chk       = {byte_s1, held_q};
		in_buf    = (cnt_q != MAX_C);
		at_end    = (cnt_q == LAST_C);
		crc_match = in_buf ? (crc_q == chk) : (crc_q == '0);
		len_new   = in_buf ? cnt_q + 1'b1 : cnt_q;
		priority if (len_new < CntW'(MIN_LEN)) begin
			status_d = ST_SHORT;
		end else if (!crc_match) begin
			status_d = ST_CRC_ERR;
		end else if (count_q < MIN_COUNT) begin
			status_d = ST_COUNT_ERR;
		end else begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			held_q  <= '0;
			cnt_q   <= '0;
			count_q <= '0;
			vhigh_q <= '0;
			vlow_q  <= '0;
		end else if (advance) begin
			if (last_s1) begin
				crc_q   <= CRC_INIT;
				held_q  <= '0;
				cnt_q   <= '0;
				count_q <= '0;
				vhigh_q <= '0;
				vlow_q  <= '0;
			end else if (in_buf) begin
				if (cnt_q == CntW'(2)) count_q <= byte_s1;
				if (cnt_q == CntW'(3)) vhigh_q <= byte_s1;
				if (cnt_q == CntW'(4)) vlow_q  <= byte_s1;
				if (at_end) begin
					crc_q <= crc_q ^ chk;
				end else begin
					if (cnt_q != '0) crc_q <= crc_folded;
					held_q <= byte_s1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= status_d;
			value_q  <= (status_d == ST_OK) ? {vhigh_q, vlow_q} : 16'h0000;
		end
	end

	assign res_valid    = res_valid_q;
	assign frame_status = status_q;
	assign frame_ok     = (status_q == ST_OK);
	assign reg_value    = value_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_C)
		else $error("byte counter past frame limit");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> cnt_q == '0 && crc_q == CRC_INIT && held_q == '0)
		else $error("frame state not reloaded after frame end");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready |-> !(advance && last_s1))
		else $error("pending result overwritten");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && status_q != ST_OK |-> value_q == 16'h0000)
		else $error("register value shown for a bad frame");

	a_crc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(crc_q) && $stable(cnt_q))
		else $error("frame state moved without a byte");

endmodule
